>>> rtl/lirs_pkg.sv
package lirs_pkg;

   // field and register widths
   localparam int SAMP_W     = 16;
   localparam int RATE_W     = 18;
   localparam int CNT_W      = 24;
   localparam int SRC_W      = 32;
   localparam int RUN_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // tick grid used to place source and result times
   localparam int unsigned TICKS_PER_SECOND = 1000000;
   localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);

   // shared divider: every quotient it is asked for stays below 2**QUOT_W
   localparam int QUOT_W    = (CNT_W > TICK_W) ? CNT_W : TICK_W;
   localparam int DEN_W     = (RATE_W > TICK_W) ? RATE_W : TICK_W;
   localparam int NUM_W     = DEN_W + QUOT_W;
   localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

   // shared multiplier
   localparam int MUL_OP_W = SRC_W + 1;
   localparam int PROD_W   = SRC_W + RATE_W + 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IN_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_COUNT = 2'd2;

   localparam logic [RATE_W-1:0] IN_RATE_RST  = 18'd44100;
   localparam logic [RATE_W-1:0] OUT_RATE_RST = 18'd48000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_E_MUL,
      ST_E_SUM,
      ST_E_CMP,
      ST_E_DIV,
      ST_RUN_SET,
      ST_Q_DIV,
      ST_R_START,
      ST_R_DIV,
      ST_POS,
      ST_T_START,
      ST_T_DIV,
      ST_FR_START,
      ST_FR_DIV,
      ST_FB_START,
      ST_FB_DIV,
      ST_VAL_CHK,
      ST_NUM_B,
      ST_NUM_C,
      ST_NUM_D,
      ST_NUM_DIV,
      ST_PUSH,
      ST_FINISH
   } lirs_state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } lirs_div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
      logic [DEN_W-1:0]  rem;
   } lirs_div_rsp_type;

endpackage

>>> rtl/lirs_if.sv
interface lirs_req_if import lirs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [SAMP_W-1:0] sample;
   logic                     last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface lirs_rsp_if import lirs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [SAMP_W-1:0] value;
   logic                     run_last;
   logic                     seq_done;
   logic                     overflow;

   modport source (output valid, output value, output run_last, output seq_done,
                   output overflow, input ready);
   modport sink (input valid, input value, input run_last, input seq_done,
                 input overflow, output ready);
endinterface

interface lirs_csr_if import lirs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/lirs_div.sv
module lirs_div import lirs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  lirs_div_req_type div_req,
   output lirs_div_rsp_type div_rsp
);

   // restoring divider, one quotient bit per cycle; the caller guarantees
   // that the quotient fits in QUOT_W bits, so the top of the numerator
   // already sits below the divisor
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [QUOT_W-1:0]    quo_ff, quo_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 fits;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[QUOT_W-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      if (div_req.start) begin
         rem_in  = div_req.numer[NUM_W-1:QUOT_W];
         quo_in  = div_req.numer[QUOT_W-1:0];
         den_in  = div_req.denom;
         cnt_in  = DIV_CNT_W'(QUOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUOT_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

>>> rtl/linear_interp_resampler_unit.sv
// Linear-interpolation sample rate converter. Each accepted item is one signed
// 16-bit source sample; it releases every pending result whose source position
// lies before it, interpolated between the previous sample and this one on a
// 1 MHz tick grid and truncated toward zero. An item marked last_sample flushes
// the remaining results up to out_count, holding that sample at both ends, and
// then returns the converter to its start state. At most MAX_RUN results are
// sent per item; the rest are skipped, still counted, and flagged with overflow.
// One item is worked on at a time and req ready is low meanwhile. All divisions
// run on one shared 24-step restoring divider and all products on one shared
// multiplier, under a small sequencer. An item takes up to one division to
// find the end of its run, then 4 to 6 divisions per result, plus any time
// spent waiting while the output register is held. The last result waits in
// an output register, so the next item can be taken meanwhile.
// Configuration writes are accepted at any time but belong to idle periods.
module linear_interp_resampler_unit import lirs_pkg::*; #(
   parameter int MAX_RUN = 64  // results sent per item, 1 to 64
) (
   input  logic        clock,
   input  logic        reset,
   lirs_req_if.sink    req_bus,
   lirs_rsp_if.source  rsp_bus,
   lirs_csr_if.sink    csr_bus
);

   // configuration
   logic [RATE_W-1:0] in_rate_ff, in_rate_in;
   logic [RATE_W-1:0] out_rate_ff, out_rate_in;
   logic [CNT_W-1:0]  out_count_ff, out_count_in;

   // converter state kept between items
   logic signed [SAMP_W-1:0] prev_ff, prev_in;
   logic                     have_prev_ff, have_prev_in;
   logic [SRC_W-1:0]         src_idx_ff, src_idx_in;
   logic [CNT_W-1:0]         out_idx_ff, out_idx_in;

   // sequencer
   lirs_state_type state_ff, state_in;

   // current item and run
   logic signed [SAMP_W-1:0] samp_ff, samp_in;
   logic                     last_ff, last_in;
   logic [CNT_W-1:0]         e_ff, e_in;       // end of run (exclusive result index)
   logic [RUN_W-1:0]         emit_ff, emit_in;
   logic [RUN_W-1:0]         k_ff, k_in;
   logic                     ovf_ff, ovf_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;   // result index being worked on

   // per-result scratch
   logic signed [PROD_W-1:0] mul_ff, mul_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic [QUOT_W-1:0]        q_ff, q_in;       // whole periods of out_rate
   logic [RATE_W-1:0]        ir_ff, ir_in;     // index within that period
   logic [RATE_W-1:0]        r_ff, r_in;       // source position within its period
   logic signed [SAMP_W-1:0] a_ff, a_in;
   logic [TICK_W-1:0]        tf_ff, tf_in;     // result time within period
   logic [TICK_W-1:0]        fr_ff, fr_in;     // left source time within period
   logic [TICK_W-1:0]        span_ff, span_in;
   logic [TICK_W-1:0]        d_ff, d_in;
   logic                     neg_ff, neg_in;
   logic signed [SAMP_W-1:0] res_ff, res_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SAMP_W-1:0] o_value_ff, o_value_in;
   logic                     o_run_last_ff, o_run_last_in;
   logic                     o_seq_done_ff, o_seq_done_in;
   logic                     o_ovf_ff, o_ovf_in;

   // shared units
   lirs_div_req_type              div_req;
   lirs_div_rsp_type              div_rsp;
   logic signed [MUL_OP_W-1:0]    mul_a;
   logic signed [MUL_OP_W-1:0]    mul_b;
   logic signed [2*MUL_OP_W-1:0]  mul_prod;

   // helpers
   logic [RATE_W-1:0]        ri_eff;
   logic [RATE_W-1:0]        ro_eff;
   logic                     req_fire;
   logic                     csr_fire;
   logic [CNT_W-1:0]         run_len;
   logic [PROD_W:0]          pos_sum;
   logic [RATE_W:0]          r_plus;
   logic [TICK_W-1:0]        d_raw;
   logic signed [SAMP_W:0]   half_sum;
   logic signed [SAMP_W:0]   step_diff;
   logic [PROD_W-1:0]        num_mag;
   logic [SAMP_W-1:0]        q16;
   logic                     run_end;
   logic                     out_free;

   lirs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign mul_prod = mul_a * mul_b;

   // a rate of zero behaves as one
   assign ri_eff = (in_rate_ff == '0) ? RATE_W'(1) : in_rate_ff;
   assign ro_eff = (out_rate_ff == '0) ? RATE_W'(1) : out_rate_ff;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid & req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.value    = o_value_ff;
   assign rsp_bus.run_last = o_run_last_ff;
   assign rsp_bus.seq_done = o_seq_done_ff;
   assign rsp_bus.overflow = o_ovf_ff;

   always_comb begin
      in_rate_in    = in_rate_ff;
      out_rate_in   = out_rate_ff;
      out_count_in  = out_count_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      src_idx_in    = src_idx_ff;
      out_idx_in    = out_idx_ff;
      state_in      = state_ff;
      samp_in       = samp_ff;
      last_in       = last_ff;
      e_in          = e_ff;
      emit_in       = emit_ff;
      k_in          = k_ff;
      ovf_in        = ovf_ff;
      idx_in        = idx_ff;
      mul_in        = mul_ff;
      acc_in        = acc_ff;
      q_in          = q_ff;
      ir_in         = ir_ff;
      r_in          = r_ff;
      a_in          = a_ff;
      tf_in         = tf_ff;
      fr_in         = fr_ff;
      span_in       = span_ff;
      d_in          = d_ff;
      neg_in        = neg_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      o_value_in    = o_value_ff;
      o_run_last_in = o_run_last_ff;
      o_seq_done_in = o_seq_done_ff;
      o_ovf_in      = o_ovf_ff;

      div_req.start = 1'b0;
      div_req.numer = '0;
      div_req.denom = '0;
      mul_a         = '0;
      mul_b         = '0;

      run_len   = (e_ff > out_idx_ff) ? e_ff - out_idx_ff : '0;
      pos_sum   = {1'b0, mul_ff} + (PROD_W + 1)'(r_ff);
      r_plus    = {1'b0, r_ff} + 1'b1;
      d_raw     = (tf_ff > fr_ff) ? tf_ff - fr_ff : '0;
      half_sum  = (SAMP_W + 1)'(a_ff >>> 1) + (SAMP_W + 1)'(samp_ff >>> 1);
      step_diff = (SAMP_W + 1)'(samp_ff) - (SAMP_W + 1)'(a_ff);
      num_mag   = acc_ff[PROD_W-1] ? PROD_W'(-acc_ff) : PROD_W'(acc_ff);
      q16       = div_rsp.quot[SAMP_W-1:0];
      run_end   = (RUN_W'(k_ff + 1'b1) == emit_ff);
      out_free  = !rsp_valid_ff || rsp_bus.ready;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_fire) begin
         case (csr_bus.index)
            CSR_IN_RATE:   in_rate_in   = csr_bus.data[RATE_W-1:0];
            CSR_OUT_RATE:  out_rate_in  = csr_bus.data[RATE_W-1:0];
            CSR_OUT_COUNT: out_count_in = csr_bus.data[CNT_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               samp_in  = req_bus.sample;
               last_in  = req_bus.last_sample;
               state_in = ST_E_MUL;
            end
         end
         // end of run: ceil(s*ro/ri), capped at out_count; out_count itself for a last item
         ST_E_MUL: begin
            mul_a    = MUL_OP_W'(src_idx_ff);
            mul_b    = MUL_OP_W'(ro_eff);
            mul_in   = $signed(mul_prod[PROD_W-1:0]);
            state_in = ST_E_SUM;
         end
         ST_E_SUM: begin
            acc_in   = mul_ff + PROD_W'(ri_eff) - PROD_W'(1);
            mul_a    = MUL_OP_W'(out_count_ff);
            mul_b    = MUL_OP_W'(ri_eff);
            mul_in   = $signed(mul_prod[PROD_W-1:0]);
            state_in = ST_E_CMP;
         end
         ST_E_CMP: begin
            if (last_ff || ($unsigned(acc_ff) >= $unsigned(mul_ff))) begin
               e_in     = out_count_ff;
               state_in = ST_RUN_SET;
            end else begin
               div_req.start = 1'b1;
               div_req.numer = acc_ff[NUM_W-1:0];
               div_req.denom = DEN_W'(ri_eff);
               state_in      = ST_E_DIV;
            end
         end
         ST_E_DIV: begin
            if (div_rsp.done) begin
               e_in     = CNT_W'(div_rsp.quot);
               state_in = ST_RUN_SET;
            end
         end
         ST_RUN_SET: begin
            if (run_len != '0) begin
               out_idx_in = e_ff;
            end
            emit_in = (run_len > CNT_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : RUN_W'(run_len);
            ovf_in  = (run_len > CNT_W'(MAX_RUN));
            k_in    = '0;
            idx_in  = out_idx_ff;
            if (run_len == '0) begin
               state_in = ST_FINISH;
            end else begin
               div_req.start = 1'b1;
               div_req.numer = NUM_W'(out_idx_ff);
               div_req.denom = DEN_W'(ro_eff);
               state_in      = ST_Q_DIV;
            end
         end
         // split the result index into whole out_rate periods and a remainder
         ST_Q_DIV: begin
            if (div_rsp.done) begin
               q_in     = div_rsp.quot;
               ir_in    = RATE_W'(div_rsp.rem);
               mul_a    = MUL_OP_W'(div_rsp.rem);
               mul_b    = MUL_OP_W'(ri_eff);
               mul_in   = $signed(mul_prod[PROD_W-1:0]);
               state_in = ST_R_START;
            end
         end
         ST_R_START: begin
            div_req.start = 1'b1;
            div_req.numer = mul_ff[NUM_W-1:0];
            div_req.denom = DEN_W'(ro_eff);
            state_in      = ST_R_DIV;
         end
         ST_R_DIV: begin
            if (div_rsp.done) begin
               r_in     = RATE_W'(div_rsp.quot);
               mul_a    = MUL_OP_W'(q_ff);
               mul_b    = MUL_OP_W'(ri_eff);
               mul_in   = $signed(mul_prod[PROD_W-1:0]);
               state_in = ST_POS;
            end
         end
         // source position decides whether the left end is the held sample
         ST_POS: begin
            if (have_prev_ff && (pos_sum < (PROD_W + 1)'(src_idx_ff))) begin
               a_in = prev_ff;
            end else begin
               a_in = samp_ff;
            end
            mul_a    = MUL_OP_W'(ir_ff);
            mul_b    = MUL_OP_W'(TICKS_PER_SECOND);
            mul_in   = $signed(mul_prod[PROD_W-1:0]);
            state_in = ST_T_START;
         end
         ST_T_START: begin
            div_req.start = 1'b1;
            div_req.numer = mul_ff[NUM_W-1:0];
            div_req.denom = DEN_W'(ro_eff);
            state_in      = ST_T_DIV;
         end
         ST_T_DIV: begin
            if (div_rsp.done) begin
               tf_in    = TICK_W'(div_rsp.quot);
               mul_a    = MUL_OP_W'(r_ff);
               mul_b    = MUL_OP_W'(TICKS_PER_SECOND);
               mul_in   = $signed(mul_prod[PROD_W-1:0]);
               state_in = ST_FR_START;
            end
         end
         ST_FR_START: begin
            div_req.start = 1'b1;
            div_req.numer = mul_ff[NUM_W-1:0];
            div_req.denom = DEN_W'(ri_eff);
            state_in      = ST_FR_DIV;
         end
         ST_FR_DIV: begin
            if (div_rsp.done) begin
               fr_in = TICK_W'(div_rsp.quot);
               if (r_plus < (RATE_W + 1)'(ri_eff)) begin
                  mul_a    = MUL_OP_W'(r_plus);
                  mul_b    = MUL_OP_W'(TICKS_PER_SECOND);
                  mul_in   = $signed(mul_prod[PROD_W-1:0]);
                  state_in = ST_FB_START;
               end else begin
                  // right end is the start of the next period
                  span_in  = TICK_W'(TICKS_PER_SECOND) - TICK_W'(div_rsp.quot);
                  state_in = ST_VAL_CHK;
               end
            end
         end
         ST_FB_START: begin
            div_req.start = 1'b1;
            div_req.numer = mul_ff[NUM_W-1:0];
            div_req.denom = DEN_W'(ri_eff);
            state_in      = ST_FB_DIV;
         end
         ST_FB_DIV: begin
            if (div_rsp.done) begin
               span_in  = TICK_W'(div_rsp.quot) - fr_ff;
               state_in = ST_VAL_CHK;
            end
         end
         ST_VAL_CHK: begin
            d_in = (d_raw > span_ff) ? span_ff : d_raw;
            if (span_ff == '0) begin
               // both ends on the same tick: average of the halves
               res_in   = half_sum[SAMP_W-1:0];
               state_in = ST_PUSH;
            end else if (a_ff == samp_ff) begin
               res_in   = a_ff;
               state_in = ST_PUSH;
            end else begin
               mul_a    = MUL_OP_W'(a_ff);
               mul_b    = MUL_OP_W'(span_ff);
               mul_in   = $signed(mul_prod[PROD_W-1:0]);
               state_in = ST_NUM_B;
            end
         end
         // numerator a*span + (b-a)*d
         ST_NUM_B: begin
            acc_in   = mul_ff;
            mul_a    = MUL_OP_W'(step_diff);
            mul_b    = MUL_OP_W'(d_ff);
            mul_in   = $signed(mul_prod[PROD_W-1:0]);
            state_in = ST_NUM_C;
         end
         ST_NUM_C: begin
            acc_in   = acc_ff + mul_ff;
            state_in = ST_NUM_D;
         end
         ST_NUM_D: begin
            neg_in        = acc_ff[PROD_W-1];
            div_req.start = 1'b1;
            div_req.numer = num_mag[NUM_W-1:0];
            div_req.denom = DEN_W'(span_ff);
            state_in      = ST_NUM_DIV;
         end
         ST_NUM_DIV: begin
            if (div_rsp.done) begin
               // divide the magnitude, then restore the sign: truncates toward zero
               res_in   = neg_ff ? $signed(-q16) : $signed(q16);
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               o_value_in    = res_ff;
               o_run_last_in = run_end;
               o_seq_done_in = run_end && (e_ff >= out_count_ff);
               o_ovf_in      = ovf_ff;
               if (run_end) begin
                  state_in = ST_FINISH;
               end else begin
                  k_in          = k_ff + 1'b1;
                  idx_in        = idx_ff + 1'b1;
                  div_req.start = 1'b1;
                  div_req.numer = NUM_W'(idx_ff + 1'b1);
                  div_req.denom = DEN_W'(ro_eff);
                  state_in      = ST_Q_DIV;
               end
            end
         end
         ST_FINISH: begin
            if (last_ff) begin
               prev_in      = '0;
               have_prev_in = 1'b0;
               src_idx_in   = '0;
               out_idx_in   = '0;
            end else begin
               prev_in      = samp_ff;
               have_prev_in = 1'b1;
               if (src_idx_ff != '1) begin
                  src_idx_in = src_idx_ff + 1'b1;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      samp_ff       <= samp_in;
      e_ff          <= e_in;
      emit_ff       <= emit_in;
      k_ff          <= k_in;
      ovf_ff        <= ovf_in;
      idx_ff        <= idx_in;
      mul_ff        <= mul_in;
      acc_ff        <= acc_in;
      q_ff          <= q_in;
      ir_ff         <= ir_in;
      r_ff          <= r_in;
      a_ff          <= a_in;
      tf_ff         <= tf_in;
      fr_ff         <= fr_in;
      span_ff       <= span_in;
      d_ff          <= d_in;
      neg_ff        <= neg_in;
      res_ff        <= res_in;
      o_value_ff    <= o_value_in;
      o_run_last_ff <= o_run_last_in;
      o_seq_done_ff <= o_seq_done_in;
      o_ovf_ff      <= o_ovf_in;
      if (reset) begin
         in_rate_ff   <= IN_RATE_RST;
         out_rate_ff  <= OUT_RATE_RST;
         out_count_ff <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         src_idx_ff   <= '0;
         out_idx_ff   <= '0;
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_rate_ff   <= in_rate_in;
         out_rate_ff  <= out_rate_in;
         out_count_ff <= out_count_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         src_idx_ff   <= src_idx_in;
         out_idx_ff   <= out_idx_in;
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> tb/sv/linear_interp_resampler_unit_test.sv
module linear_interp_resampler_unit_test;
   import lirs_pkg::*;

   // results sent per item before the rest of a run is skipped
   localparam int RUN_LIMIT = 64;
   // quiet cycles with no item moving on any channel before giving up
   localparam int WATCHDOG_LIMIT = 5000;
   // cycles left after the last result so a run with no results can finish
   localparam int DRAIN_CYCLES = 200;
   // register index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam longint unsigned TICK_RATE = 64'd1000000;

   typedef struct {
      logic signed [SAMP_W-1:0] amp;
      logic                     last;
   } source_item_t;

   typedef struct {
      logic signed [SAMP_W-1:0] value;
      logic                     run_last;
      logic                     seq_done;
      logic                     overflow;
   } resampled_out_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lirs_req_if req_bus ();
   lirs_rsp_if rsp_bus ();
   lirs_csr_if csr_bus ();

   linear_interp_resampler_unit #(.MAX_RUN(RUN_LIMIT)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // source items waiting for the driver, results waiting for the monitor
   source_item_t   pending_samples[$];
   resampled_out_t expected_outputs[$];

   // shadow copy of the converter: registers and sequence state
   logic [RATE_W-1:0]        model_in_rate   = IN_RATE_RST;
   logic [RATE_W-1:0]        model_out_rate  = OUT_RATE_RST;
   logic [CNT_W-1:0]         model_out_count = '0;
   logic signed [SAMP_W-1:0] model_prev      = '0;
   logic                     model_have_prev = 1'b0;
   logic [SRC_W-1:0]         model_src_index = '0;
   logic [CNT_W-1:0]         model_out_index = '0;

   int error_count   = 0;
   int queued_items  = 0;
   int quiet_cycles  = 0;
   int req_gap       = 0;
   int rsp_gap       = 0;
   int rsp_hold_left = 0;
   bit idle_enabled  = 1'b1;

   int unsigned audio_rates[11] = '{8000, 11025, 16000, 22050, 32000, 44100,
                                    48000, 88200, 96000, 176400, 192000};
   // zero counts as one, top of the register is past the nominal range
   int unsigned corner_rates[4] = '{0, 1, 192000, 262143};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // value between two source amplitudes for result index i, truncated toward zero
   function automatic int interp_value(input longint unsigned i, input longint unsigned pos,
                                       input int a, input int b,
                                       input longint unsigned ri, input longint unsigned ro);
      longint unsigned q, r, fr, span, ta, t, d;
      longint num;
      q  = pos / ri;
      r  = pos % ri;
      fr = r * TICK_RATE / ri;
      if (r + 1 < ri) span = (r + 1) * TICK_RATE / ri - fr;
      else span = TICK_RATE - fr;
      // both ends land on one tick: average of halves, rounded down each
      if (span == 0) return (a >>> 1) + (b >>> 1);
      if (a == b) return a;
      ta = q * TICK_RATE + fr;
      t  = i * TICK_RATE / ro;
      d  = (t > ta) ? t - ta : 64'd0;
      if (d > span) d = span;
      num = longint'(a) * longint'(span) + longint'(b - a) * longint'(d);
      return int'(num / longint'(span));
   endfunction

   // results released by one accepted source item, then the state update
   task automatic predict_outputs(input logic signed [SAMP_W-1:0] amp, input logic last);
      longint unsigned ri, ro, s, oc, oi, e, n, emit, i, pos;
      int a, b, v;
      bit ovf;
      resampled_out_t r;
      ri = (model_in_rate == '0) ? 64'd1 : 64'(model_in_rate);
      ro = (model_out_rate == '0) ? 64'd1 : 64'(model_out_rate);
      s  = 64'(model_src_index);
      oc = 64'(model_out_count);
      oi = 64'(model_out_index);
      // end of the run: every result whose source position lies before this item,
      // or all that remain when the sequence ends here
      if (last) e = oc;
      else begin
         e = (s * ro + ri - 1) / ri;
         if (e > oc) e = oc;
      end
      n    = (e > oi) ? e - oi : 64'd0;
      ovf  = n > 64'(RUN_LIMIT);
      emit = ovf ? 64'(RUN_LIMIT) : n;
      for (longint unsigned k = 0; k < emit; k++) begin
         i   = oi + k;
         pos = i * ri / ro;
         b   = amp;
         // past the end of the source the final item stands at both ends
         a   = (model_have_prev && pos < s) ? int'(model_prev) : b;
         v   = interp_value(i, pos, a, b, ri, ro);
         r.value    = v[SAMP_W-1:0];
         r.run_last = (k + 1 == emit);
         r.seq_done = r.run_last && (e >= oc);
         r.overflow = ovf;
         expected_outputs.push_back(r);
      end
      if (n > 0) model_out_index = e[CNT_W-1:0];
      if (last) begin
         model_prev      = '0;
         model_have_prev = 1'b0;
         model_src_index = '0;
         model_out_index = '0;
      end else begin
         model_prev      = amp;
         model_have_prev = 1'b1;
         if (model_src_index != '1) model_src_index = model_src_index + 1'b1;
      end
   endtask

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endfunction

   task automatic push_item(input logic signed [SAMP_W-1:0] amp, input logic last);
      source_item_t item;
      item.amp  = amp;
      item.last = last;
      pending_samples.push_back(item);
      queued_items++;
   endtask

   // one register write on its own channel, mirrored into the shadow copy
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_IN_RATE:   model_in_rate = value[RATE_W-1:0];
         CSR_OUT_RATE:  model_out_rate = value[RATE_W-1:0];
         CSR_OUT_COUNT: model_out_count = value[CNT_W-1:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   task automatic configure(input int unsigned ri, input int unsigned ro, input int unsigned oc);
      logic [CSR_DATA_W-RATE_W-1:0] junk;
      logic [31:0] bits;
      // unused upper data bits of the rate registers now and then
      bits = $urandom;
      junk = ($urandom_range(0, 3) == 0) ? bits[CSR_DATA_W-RATE_W-1:0] : '0;
      write_register(CSR_IN_RATE, {junk, ri[RATE_W-1:0]});
      bits = $urandom;
      junk = ($urandom_range(0, 3) == 0) ? bits[CSR_DATA_W-RATE_W-1:0] : '0;
      write_register(CSR_OUT_RATE, {junk, ro[RATE_W-1:0]});
      write_register(CSR_OUT_COUNT, oc[CNT_W-1:0]);
   endtask

   // idle point: nothing left to send, every result in, then the tail of the last item
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_bus.valid || expected_outputs.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random source amplitudes with extremes, flat stretches and values near zero
   task automatic queue_sequence(input int unsigned len, input bit end_with_last);
      logic signed [SAMP_W-1:0] amp, prior;
      logic last;
      prior = '0;
      for (int unsigned k = 0; k < len; k++) begin
         case ($urandom_range(0, 7))
            0: amp = 16'sh8000;
            1: amp = 16'sh7fff;
            2: amp = prior;
            3: amp = 16'($urandom_range(0, 16)) - 16'sd8;
            default: amp = 16'($urandom);
         endcase
         // a stray end marker now and then cuts the sequence short
         last = (end_with_last && k == len - 1) || ($urandom_range(0, 40) == 0);
         push_item(amp, last);
         prior = amp;
      end
   endtask

   // source side: offers queued items, predicts at each accepted one
   always @(posedge clock) begin : sample_driver
      source_item_t item;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predict_outputs(req_bus.sample, req_bus.last_sample);
         // the offer only changes once the previous item is taken
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (idle_enabled && pending_samples.size() != 0 &&
                         $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(0, 2);
               req_bus.valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               item = pending_samples.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.sample      <= item.amp;
               req_bus.last_sample <= item.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result side: checks each accepted result against the oldest prediction
   always @(posedge clock) begin : result_monitor
      resampled_out_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_outputs.size() == 0) begin
               note_error($sformatf("unexpected item: value %0d run_last %0b seq_done %0b overflow %0b",
                                    rsp_bus.value, rsp_bus.run_last, rsp_bus.seq_done,
                                    rsp_bus.overflow));
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_bus.value !== want.value || rsp_bus.run_last !== want.run_last ||
                   rsp_bus.seq_done !== want.seq_done || rsp_bus.overflow !== want.overflow)
                  note_error($sformatf({"mismatch: expected value %0d run_last %0b seq_done %0b ",
                                        "overflow %0b, got value %0d run_last %0b seq_done %0b ",
                                        "overflow %0b"},
                                       want.value, want.run_last, want.seq_done, want.overflow,
                                       rsp_bus.value, rsp_bus.run_last, rsp_bus.seq_done,
                                       rsp_bus.overflow));
            end
         end
         // long hold-off first, then short random stalls
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles where nothing moves on any channel
   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned ri, ro, oc, len, eff_ri, eff_ro, nominal_count;
      bit extreme;

      req_bus.valid       = 1'b0;
      req_bus.sample      = '0;
      req_bus.last_sample = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_IN_RATE;
      csr_bus.data        = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: out_count of zero, nothing may come out
      push_item(16'sh8000, 1'b0);
      push_item(16'sh7fff, 1'b1);
      wait_drained();

      // common audio ratio, full-scale swings, a flat pair, end marker flushes the rest
      configure(44100, 48000, 10);
      push_item(16'sh7fff, 1'b0);
      push_item(16'sh8000, 1'b0);
      push_item(16'sh0000, 1'b0);
      push_item(-16'sd1, 1'b0);
      push_item(16'sh7fff, 1'b0);
      push_item(16'sh7fff, 1'b0);
      push_item(16'sh8000, 1'b0);
      push_item(16'sd1, 1'b1);
      wait_drained();

      // huge upsampling: one item owes far more than a run allows
      configure(1, 192000, 300);
      push_item(16'sd100, 1'b0);
      push_item(-16'sd100, 1'b0);
      push_item(16'sd5, 1'b1);
      wait_drained();

      // end marker with the largest count: flushed run overflows and ends the sequence
      configure(48000, 48000, 24'hffffff);
      push_item(-16'sd12345, 1'b1);
      wait_drained();

      // zero rates count as one; then the count drops below what was already produced
      configure(0, 0, 3);
      write_register(CSR_UNUSED, '1);
      push_item(16'sd7, 1'b0);
      push_item(-16'sd7, 1'b0);
      push_item(16'sd1000, 1'b0);
      wait_drained();
      write_register(CSR_OUT_COUNT, 24'd1);
      push_item(16'sd3, 1'b0);
      push_item(16'sd4, 1'b1);
      wait_drained();

      // widest rate field against the slowest target: results are rare
      configure(262143, 1, 1);
      push_item(-16'sd1, 1'b0);
      push_item(16'sh7fff, 1'b0);
      push_item(16'sh8000, 1'b1);
      wait_drained();

      // backpressure: results held off long enough that the converter stops taking items
      configure(48000, 48000, 24);
      queue_sequence(24, 1'b1);
      while (pending_samples.size() > 20) @(negedge clock);
      @(negedge clock);
      rsp_hold_left = 400;
      wait_drained();

      // random sequences; each starts from an idle converter
      while (queued_items < 440) begin
         extreme = ($urandom_range(0, 9) == 0);
         if (extreme) begin
            ri  = corner_rates[$urandom_range(0, 3)];
            ro  = corner_rates[$urandom_range(0, 3)];
            len = $urandom_range(2, 3);
         end else begin
            ri  = ($urandom_range(0, 2) == 0) ? $urandom_range(1000, 192000)
                                              : audio_rates[$urandom_range(0, 10)];
            ro  = ($urandom_range(0, 2) == 0) ? $urandom_range(1000, 192000)
                                              : audio_rates[$urandom_range(0, 10)];
            // keep runs per item short so the result stream stays dense but cheap
            if (ro > 4 * ri) ro = 4 * ri;
            len = $urandom_range(5, 30);
         end
         eff_ri = (ri == 0) ? 1 : ri;
         eff_ro = (ro == 0) ? 1 : ro;
         nominal_count = len * eff_ro / eff_ri;
         if (nominal_count > 24'hffffff) nominal_count = 24'hffffff;
         case ($urandom_range(0, 9))
            0: oc = 0;
            1: oc = 24'hffffff;
            2: oc = $urandom_range(0, 24'hffffff);
            3, 4: oc = nominal_count / 2;
            default: oc = nominal_count + $urandom_range(0, 8);
         endcase
         if (oc > 24'hffffff) oc = 24'hffffff;
         // no idling near the end, and now and then a sequence without it
         idle_enabled = (queued_items < 400) && ($urandom_range(0, 3) != 0);
         configure(ri, ro, oc);
         // mostly well-formed sequences; some stop without an end marker
         queue_sequence(len, $urandom_range(0, 5) != 0);
         wait_drained();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> linear_interp_resampler_unit.f
rtl/lirs_pkg.sv
rtl/lirs_if.sv
rtl/lirs_div.sv
rtl/linear_interp_resampler_unit.sv
tb/sv/linear_interp_resampler_unit_test.sv
